// File: rtl/core/oas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package oas_pkg;

  // Default parameter values
  localparam int unsigned DistBitsDef      = 10;
  localparam int unsigned TurnCountBitsDef = 16;

  // Fixed register field widths
  localparam int unsigned SpeedW   = 8;
  localparam int unsigned LimitW   = 10;
  localparam int unsigned NeededW  = 4;
  localparam int unsigned DelayW   = 8;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  // Register reset values
  localparam logic [SpeedW-1:0]  DriveSpeedRst     = 8'd125;
  localparam logic [LimitW-1:0]  AlignToleranceRst = 10'd8;
  localparam logic [LimitW-1:0]  NearLimitRst      = 10'd160;
  localparam logic [LimitW-1:0]  ClearLimitRst     = 10'd176;
  localparam logic [NeededW-1:0] ClearNeededRst    = 4'd3;
  localparam logic [DelayW-1:0]  DelayTicksRst     = 8'd10;

  // Register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_DRIVE_SPEED     = 3'd0,
    REG_ALIGN_TOLERANCE = 3'd1,
    REG_NEAR_LIMIT      = 3'd2,
    REG_CLEAR_LIMIT     = 3'd3,
    REG_CLEAR_NEEDED    = 3'd4,
    REG_DELAY_TICKS     = 3'd5
  } reg_idx_e;

  // Input actions
  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_TURN   = 2'd2,
    ACT_DELAY  = 2'd3
  } action_e;

  // Maneuver phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_REV    = 3'd1,
    PH_RIGHT  = 3'd2,
    PH_FWD    = 3'd3,
    PH_FDELAY = 3'd4,
    PH_LEFT   = 3'd5
  } phase_e;

  // Configuration register set
  typedef struct packed {
    logic [SpeedW-1:0]  drive_speed;
    logic [LimitW-1:0]  align_tolerance;
    logic [LimitW-1:0]  near_limit;
    logic [LimitW-1:0]  clear_limit;
    logic [NeededW-1:0] clear_needed;
    logic [DelayW-1:0]  delay_ticks;
  } cfg_t;

  // One result transaction
  typedef struct packed {
    logic              left_forward;
    logic              right_forward;
    logic [SpeedW-1:0] left_speed;
    logic [SpeedW-1:0] right_speed;
    phase_e            phase_now;
    logic              finished;
    logic              aborted;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/obstacle_avoid_sequencer_unit.sv
// Obstacle-avoidance maneuver sequencer for a two-motor vehicle.
//
// Input channel (in_valid_i / in_stall_o) carries one event per transaction:
// start, sensor sample, turn-timer tick or delay-timer tick, with two
// distances and an emergency-stop flag. Output channel (out_valid_o /
// out_stall_i) returns exactly one result per input: motor directions and
// duty values, the phase after the event, and finished / aborted flags.
// A transaction moves when valid is high and stall is low at a clock edge.
//
// An accepted input's result is registered. One transaction per cycle is
// taken while in_stall_o is low: the phase update is a single
// compare-and-count step between the state registers and the result
// register. When the receiver stalls, one further result is parked in a
// skid stage; in_stall_o rises only once that stage is full.
//
// Reset (rst_ni low, asynchronous) returns to idle with all counters zero,
// empties the output path and loads the register defaults. The user writes
// registers on APB at byte address 4*index while idle; it is unenforced.
`timescale 1ns / 1ps
`default_nettype none

module obstacle_avoid_sequencer_unit
  import oas_pkg::*;
#(
  parameter int unsigned DIST_BITS       = DistBitsDef,
  parameter int unsigned TURN_COUNT_BITS = TurnCountBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrW-1:0]     paddr,
  input  wire logic [DataW-1:0]     pwdata,
  output logic [DataW-1:0]          prdata,
  output logic                      pready,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           action_i,
  input  wire logic [DIST_BITS-1:0] dist_first_i,
  input  wire logic [DIST_BITS-1:0] dist_second_i,
  input  wire logic                 emergency_stop_i,
  // output channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      left_forward_o,
  output logic                      right_forward_o,
  output logic [SpeedW-1:0]         left_speed_o,
  output logic [SpeedW-1:0]         right_speed_o,
  output logic [2:0]                phase_now_o,
  output logic                      finished_o,
  output logic                      aborted_o
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;
  logic     in_fire;
  result_t  res_d, res_q;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drive_speed     <= DriveSpeedRst;
      cfg_q.align_tolerance <= AlignToleranceRst;
      cfg_q.near_limit      <= NearLimitRst;
      cfg_q.clear_limit     <= ClearLimitRst;
      cfg_q.clear_needed    <= ClearNeededRst;
      cfg_q.delay_ticks     <= DelayTicksRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DRIVE_SPEED:     cfg_q.drive_speed     <= pwdata[SpeedW-1:0];
        REG_ALIGN_TOLERANCE: cfg_q.align_tolerance <= pwdata[LimitW-1:0];
        REG_NEAR_LIMIT:      cfg_q.near_limit      <= pwdata[LimitW-1:0];
        REG_CLEAR_LIMIT:     cfg_q.clear_limit     <= pwdata[LimitW-1:0];
        REG_CLEAR_NEEDED:    cfg_q.clear_needed    <= pwdata[NeededW-1:0];
        REG_DELAY_TICKS:     cfg_q.delay_ticks     <= pwdata[DelayW-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      REG_DRIVE_SPEED:     prdata = DataW'(cfg_q.drive_speed);
      REG_ALIGN_TOLERANCE: prdata = DataW'(cfg_q.align_tolerance);
      REG_NEAR_LIMIT:      prdata = DataW'(cfg_q.near_limit);
      REG_CLEAR_LIMIT:     prdata = DataW'(cfg_q.clear_limit);
      REG_CLEAR_NEEDED:    prdata = DataW'(cfg_q.clear_needed);
      REG_DELAY_TICKS:     prdata = DataW'(cfg_q.delay_ticks);
      default:             prdata = '0;
    endcase
  end

  assign in_fire = in_valid_i && !in_stall_o;

  oas_core #(
    .DIST_BITS       (DIST_BITS),
    .TURN_COUNT_BITS (TURN_COUNT_BITS)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (in_fire),
    .cfg_i            (cfg_q),
    .action_i         (action_i),
    .dist_first_i     (dist_first_i),
    .dist_second_i    (dist_second_i),
    .emergency_stop_i (emergency_stop_i),
    .result_o         (res_d)
  );

  oas_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_i      (res_d),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (res_q)
  );

  // Unpack the result transaction
  assign left_forward_o  = res_q.left_forward;
  assign right_forward_o = res_q.right_forward;
  assign left_speed_o    = res_q.left_speed;
  assign right_speed_o   = res_q.right_speed;
  assign phase_now_o     = res_q.phase_now;
  assign finished_o      = res_q.finished;
  assign aborted_o       = res_q.aborted;

endmodule

`default_nettype wire

// File: rtl/core/oas_core.sv
`timescale 1ns / 1ps
`default_nettype none

module oas_core
  import oas_pkg::*;
#(
  parameter int unsigned DIST_BITS       = DistBitsDef,
  parameter int unsigned TURN_COUNT_BITS = TurnCountBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 fire_i,
  input  wire cfg_t                 cfg_i,
  input  wire logic [1:0]           action_i,
  input  wire logic [DIST_BITS-1:0] dist_first_i,
  input  wire logic [DIST_BITS-1:0] dist_second_i,
  input  wire logic                 emergency_stop_i,
  output result_t                   result_o
);

  localparam int unsigned CmpW = (DIST_BITS > LimitW) ? DIST_BITS : LimitW;

  phase_e                     phase_q, phase_d;
  logic [TURN_COUNT_BITS-1:0] turn_ticks_q, turn_ticks_d;
  logic [NeededW-1:0]         clear_run_q, clear_run_d;
  logic [DelayW-1:0]          delay_cnt_q, delay_cnt_d;

  logic [CmpW-1:0]            d1_w, d2_w, diff_w;
  logic [TURN_COUNT_BITS-1:0] turn_inc, turn_dec;
  logic [NeededW-1:0]         clear_inc;
  logic [DelayW-1:0]          delay_inc;
  logic                       delay_done, aligned, is_clear;
  logic                       done, abort;
  action_e                    act;

  // Distance compares at a common width
  assign d1_w       = CmpW'(dist_first_i);
  assign d2_w       = CmpW'(dist_second_i);
  assign diff_w     = (d1_w >= d2_w) ? (d1_w - d2_w) : (d2_w - d1_w);
  assign aligned    = (diff_w <= CmpW'(cfg_i.align_tolerance)) &&
                      (d1_w < CmpW'(cfg_i.near_limit));
  assign is_clear   = (d1_w >= CmpW'(cfg_i.clear_limit));

  assign turn_inc   = turn_ticks_q + TURN_COUNT_BITS'(1);
  assign turn_dec   = turn_ticks_q - TURN_COUNT_BITS'(1);
  assign clear_inc  = clear_run_q + NeededW'(1);
  assign delay_inc  = delay_cnt_q + DelayW'(1);
  assign delay_done = (delay_inc >= cfg_i.delay_ticks);
  assign act        = action_e'(action_i);

  // Next state for one transaction
  always_comb begin
    phase_d      = phase_q;
    turn_ticks_d = turn_ticks_q;
    clear_run_d  = clear_run_q;
    delay_cnt_d  = delay_cnt_q;
    done         = 1'b0;
    abort        = 1'b0;
    if (emergency_stop_i) begin
      if (phase_q inside {PH_REV, PH_RIGHT, PH_FWD, PH_FDELAY, PH_LEFT}) begin
        phase_d = PH_IDLE;
        abort   = 1'b1;
      end
    end else begin
      case (phase_q)
        PH_REV: begin
          if (act == ACT_DELAY) begin
            delay_cnt_d = delay_inc;
            if (delay_done) begin
              turn_ticks_d = '0;
              phase_d      = PH_RIGHT;
            end
          end
        end
        PH_RIGHT: begin
          if (act == ACT_TURN) begin
            turn_ticks_d = turn_inc;
          end else if (act == ACT_SAMPLE && aligned) begin
            clear_run_d = '0;
            phase_d     = PH_FWD;
          end
        end
        PH_FWD: begin
          if (act == ACT_SAMPLE) begin
            if (is_clear) begin
              clear_run_d = clear_inc;
              if (clear_inc >= cfg_i.clear_needed) begin
                clear_run_d = '0;
                delay_cnt_d = '0;
                if (cfg_i.delay_ticks != '0) begin
                  phase_d = PH_FDELAY;
                end else if (turn_ticks_q == '0) begin
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end else begin
                  phase_d = PH_LEFT;
                end
              end
            end else begin
              clear_run_d = '0;
            end
          end
        end
        PH_FDELAY: begin
          if (act == ACT_DELAY) begin
            delay_cnt_d = delay_inc;
            if (delay_done) begin
              if (turn_ticks_q == '0) begin
                phase_d = PH_IDLE;
                done    = 1'b1;
              end else begin
                phase_d = PH_LEFT;
              end
            end
          end
        end
        PH_LEFT: begin
          if (act == ACT_TURN) begin
            turn_ticks_d = turn_dec;
            if (turn_dec == '0) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
          if (act == ACT_START) begin
            delay_cnt_d = '0;
            if (cfg_i.delay_ticks == '0) begin
              turn_ticks_d = '0;
              phase_d      = PH_RIGHT;
            end else begin
              phase_d = PH_REV;
            end
          end
        end
      endcase
    end
  end

  // Motor drive from the phase after this transaction
  always_comb begin
    result_o.phase_now   = phase_d;
    result_o.finished    = done;
    result_o.aborted     = abort;
    result_o.left_speed  = cfg_i.drive_speed;
    result_o.right_speed = cfg_i.drive_speed;
    case (phase_d)
      PH_REV: begin
        result_o.left_forward  = 1'b0;
        result_o.right_forward = 1'b0;
      end
      PH_RIGHT: begin
        result_o.left_forward  = 1'b1;
        result_o.right_forward = 1'b0;
      end
      PH_FWD, PH_FDELAY: begin
        result_o.left_forward  = 1'b1;
        result_o.right_forward = 1'b1;
      end
      PH_LEFT: begin
        result_o.left_forward  = 1'b0;
        result_o.right_forward = 1'b1;
      end
      default: begin
        result_o.left_forward  = 1'b1;
        result_o.right_forward = 1'b1;
        result_o.left_speed    = '0;
        result_o.right_speed   = '0;
      end
    endcase
  end

  // Advance state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      turn_ticks_q <= '0;
      clear_run_q  <= '0;
      delay_cnt_q  <= '0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      turn_ticks_q <= turn_ticks_d;
      clear_run_q  <= clear_run_d;
      delay_cnt_q  <= delay_cnt_d;
    end
  end

  // The left turn is only ever held with ticks left to unwind
  a_left_has_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LEFT) |-> (turn_ticks_q != '0))
    else $error("left turn with zero turn count");

  // A finished maneuver lands in idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && done |=> (phase_q == PH_IDLE))
    else $error("finish did not return to idle");

  // An abort only comes from an active maneuver and ends it
  a_abort_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && abort |-> (phase_q != PH_IDLE) && !done ##1 (phase_q == PH_IDLE))
    else $error("abort from idle or not returning to idle");

endmodule

`default_nettype wire

// File: rtl/core/oas_obuf.sv
`timescale 1ns / 1ps
`default_nettype none

module oas_obuf
  import oas_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire result_t data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output result_t      data_o
);

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    accept, out_fire, slot_free;

  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign slot_free   = out_fire || !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign data_o      = out_q;

  // Valid flags: output register first, skid stage behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q  <= skid_valid_q || accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload moves, no reset
  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= data_i;
      end
    end else if (accept) begin
      skid_q <= data_i;
    end
  end

  // The skid stage only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full with output register empty");

  // A drained skid entry moves into the output register
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_fire |=> out_valid_q && !skid_valid_q)
    else $error("skid entry lost on drain");

  // A stalled result holds its payload
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("stalled result changed");

endmodule

`default_nettype wire
